/* sv/dorc_pkg.sv */
// ---------------------------------------------------------------------------
// Dimension-order route compute package
// Shared widths, register index codes and the structures that travel
// between the configuration, route and emission stages.
// ---------------------------------------------------------------------------
package dorc_pkg;

   localparam int DIMS_DEF       = 4;
   localparam int COORD_BITS_DEF = 8;

   localparam int PORT_W      = 13;
   localparam int VC_W        = 4;
   localparam int TERM_W      = 6;
   localparam int COORDS_W    = 32;
   localparam int LINK_W      = 3;
   localparam int VCS_W       = 5;
   localparam int DIM_CNT_W   = 3;
   localparam int TPR_W       = 7;
   localparam int LINK_FLD_W  = 4;
   localparam int MAX_LINKS   = 4;
   localparam int MAX_VCS     = 16;

   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 24;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_ROUTER_COORDS   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIM_SIZES       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIM_LINK_COUNTS = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIM_COUNT       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TERMINALS       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_VC_COUNT        = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_USE_ALL_VCS     = 3'd6;

   typedef struct packed {
      logic [COORDS_W-1:0]   router_coords;
      logic [COORDS_W-1:0]   dim_sizes;
      logic [15:0]           dim_link_counts;
      logic [DIM_CNT_W-1:0]  dim_count;
      logic [TPR_W-1:0]      terminals_per_router;
      logic [VCS_W-1:0]      vc_count;
      logic                  use_all_vcs;
   } cfg_type;

   // One computed route: ports are first + ((start + n) mod links), n = 0..links-1.
   typedef struct packed {
      logic [PORT_W-1:0] first;
      logic [LINK_W-1:0] links;
      logic [1:0]        start;
      logic              all_vcs;
      logic [VCS_W-1:0]  vcs;
      logic [VC_W-1:0]   cur_vc;
   } route_type;

endpackage

/* sv/dorc_csr.sv */
// ---------------------------------------------------------------------------
// Configuration registers
// Holds the router's coordinates, dimension sizes, link counts and VC setup.
// ---------------------------------------------------------------------------
module dorc_csr
   import dorc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.router_coords        <= '0;
         cfg_ff.dim_sizes            <= '0;
         cfg_ff.dim_link_counts      <= '0;
         cfg_ff.dim_count            <= DIM_CNT_W'(1);
         cfg_ff.terminals_per_router <= TPR_W'(1);
         cfg_ff.vc_count             <= VCS_W'(1);
         cfg_ff.use_all_vcs          <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ROUTER_COORDS:   cfg_ff.router_coords        <= csr_wdata;
            CSR_DIM_SIZES:       cfg_ff.dim_sizes            <= csr_wdata;
            CSR_DIM_LINK_COUNTS: cfg_ff.dim_link_counts      <= csr_wdata[15:0];
            CSR_DIM_COUNT:       cfg_ff.dim_count            <= csr_wdata[DIM_CNT_W-1:0];
            CSR_TERMINALS:       cfg_ff.terminals_per_router <= csr_wdata[TPR_W-1:0];
            CSR_VC_COUNT:        cfg_ff.vc_count             <= csr_wdata[VCS_W-1:0];
            CSR_USE_ALL_VCS:     cfg_ff.use_all_vcs          <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

/* sv/dorc_route.sv */
// ---------------------------------------------------------------------------
// Route computation stage
// Registers the request, finds the first differing dimension or else the terminal,
// accumulates the port base and registers a compact description of the port set.
// ---------------------------------------------------------------------------
module dorc_route
   import dorc_pkg::*;
#(
   parameter int MAX_DIMS   = DIMS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   route_valid,
   output route_type              route,
   input  logic                   route_release
);

   localparam logic [PORT_W:0] PORT_SPAN = (PORT_W+1)'(1) << PORT_W;

   logic                in_valid_ff;
   logic [TERM_W-1:0]   in_terminal_ff;
   logic [COORDS_W-1:0] in_coords_ff;
   logic [VC_W-1:0]     in_vc_ff;
   logic                route_valid_ff;
   route_type           route_ff;
   route_type           route_in;
   logic                route_load;

   logic [COORD_BITS-1:0] rc_dim    [MAX_DIMS];
   logic [COORD_BITS-1:0] dc_dim    [MAX_DIMS];
   logic [COORD_BITS-1:0] size_dim  [MAX_DIMS];
   logic [LINK_W-1:0]     links_dim [MAX_DIMS];
   logic [PORT_W-1:0]     term_dim  [MAX_DIMS];

   logic [DIM_CNT_W-1:0]  ndims;
   logic                  matched;
   logic                  found;
   logic [PORT_W-1:0]     base;
   logic [COORD_BITS-1:0] sel_src;
   logic [COORD_BITS-1:0] sel_dst;
   logic [COORD_BITS-1:0] sel_size;
   logic [LINK_W-1:0]     sel_links;
   logic [PORT_W-1:0]     dst_wrap;
   logic [PORT_W-1:0]     offset;
   logic [PORT_W:0]       top_sum;

   // The route register frees up when empty or when its last result goes out.
   assign route_load = !route_valid_ff || route_release;
   assign req_tready = !in_valid_ff || route_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         route_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (route_load) begin
            route_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_terminal_ff <= req_tdata[TERM_W-1:0];
         in_coords_ff   <= req_tdata[TERM_W +: COORDS_W];
         in_vc_ff       <= req_tdata[TERM_W+COORDS_W +: VC_W];
      end
      if (route_load && in_valid_ff) begin
         route_ff <= route_in;
      end
   end

   always_comb begin
      for (int d = 0; d < MAX_DIMS; d++) begin
         rc_dim[d]   = cfg.router_coords[d*COORD_BITS +: COORD_BITS];
         dc_dim[d]   = in_coords_ff[d*COORD_BITS +: COORD_BITS];
         size_dim[d] = cfg.dim_sizes[d*COORD_BITS +: COORD_BITS];
         if (cfg.dim_link_counts[d*LINK_FLD_W +: LINK_FLD_W] == '0) begin
            links_dim[d] = LINK_W'(1);
         end else if (cfg.dim_link_counts[d*LINK_FLD_W +: LINK_FLD_W] >
                      LINK_FLD_W'(MAX_LINKS)) begin
            links_dim[d] = LINK_W'(MAX_LINKS);
         end else begin
            links_dim[d] = cfg.dim_link_counts[d*LINK_FLD_W +: LINK_W];
         end
         term_dim[d] = PORT_W'((PORT_W'(size_dim[d]) - PORT_W'(1)) * PORT_W'(links_dim[d]));
      end
   end

   always_comb begin
      if (cfg.dim_count == '0) begin
         ndims = DIM_CNT_W'(1);
      end else if (cfg.dim_count > DIM_CNT_W'(MAX_DIMS)) begin
         ndims = DIM_CNT_W'(MAX_DIMS);
      end else begin
         ndims = cfg.dim_count;
      end

      matched   = 1'b1;
      found     = 1'b0;
      base      = PORT_W'(cfg.terminals_per_router);
      sel_src   = '0;
      sel_dst   = '0;
      sel_size  = '0;
      sel_links = LINK_W'(1);
      for (int d = 0; d < MAX_DIMS; d++) begin
         if (matched && (DIM_CNT_W'(d) < ndims)) begin
            if (rc_dim[d] != dc_dim[d]) begin
               matched   = 1'b0;
               found     = 1'b1;
               sel_src   = rc_dim[d];
               sel_dst   = dc_dim[d];
               sel_size  = size_dim[d];
               sel_links = links_dim[d];
            end else begin
               base = base + term_dim[d];
            end
         end
      end

      // A destination behind us in the ring is reached by wrapping around.
      dst_wrap = PORT_W'(sel_dst) + ((sel_dst < sel_src) ? PORT_W'(sel_size) : '0);
      offset   = PORT_W'((dst_wrap - PORT_W'(sel_src) - PORT_W'(1)) * PORT_W'(sel_links));

      if (found) begin
         route_in.first = base + offset;
         route_in.links = sel_links;
      end else begin
         route_in.first = PORT_W'(in_terminal_ff);
         route_in.links = LINK_W'(1);
      end

      // Ports that wrap past the top of the port space sort first, so emission
      // starts at the first wrapped link.
      top_sum = (PORT_W+1)'(route_in.first) + (PORT_W+1)'(route_in.links);
      if (top_sum > PORT_SPAN) begin
         route_in.start = 2'(route_in.links - LINK_W'(top_sum - PORT_SPAN));
      end else begin
         route_in.start = 2'd0;
      end

      route_in.all_vcs = cfg.use_all_vcs;
      if (cfg.vc_count == '0) begin
         route_in.vcs = VCS_W'(1);
      end else if (cfg.vc_count > VCS_W'(MAX_VCS)) begin
         route_in.vcs = VCS_W'(MAX_VCS);
      end else begin
         route_in.vcs = cfg.vc_count;
      end
      route_in.cur_vc = in_vc_ff;
   end

   assign route_valid = route_valid_ff;
   assign route       = route_ff;

endmodule

/* sv/dorc_emit.sv */
// ---------------------------------------------------------------------------
// Result emitter
// Walks the port set of one route in ascending port order, then VC order, and
// drives one port and VC pair per cycle into the output register while not stalled.
// ---------------------------------------------------------------------------
module dorc_emit
   import dorc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              route_valid,
   input  route_type         route,
   output logic              route_release,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [PORT_W-1:0] out_port,
   output logic [VC_W-1:0]   out_vc,
   output logic              out_last
);

   logic [1:0]        pos_ff;
   logic [VC_W-1:0]   vc_ff;
   logic              rsp_valid_ff;
   logic [PORT_W-1:0] port_ff;
   logic [VC_W-1:0]   vc_out_ff;
   logic              last_ff;

   logic              take;
   logic [LINK_W-1:0] idx_raw;
   logic [LINK_W-1:0] idx;
   logic [VCS_W-1:0]  nv;
   logic              vc_last;
   logic              pos_last;
   logic              is_last;

   assign take = route_valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      idx_raw = LINK_W'(route.start) + LINK_W'(pos_ff);
      idx     = (idx_raw >= route.links) ? idx_raw - route.links : idx_raw;
      nv      = route.all_vcs ? route.vcs : VCS_W'(1);
      vc_last  = (VCS_W'(vc_ff) + VCS_W'(1)) == nv;
      pos_last = (LINK_W'(pos_ff) + LINK_W'(1)) == route.links;
      is_last  = vc_last && pos_last;
   end

   assign route_release = take && is_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
         vc_ff        <= '0;
      end else begin
         if (take) begin
            rsp_valid_ff <= 1'b1;
            if (is_last) begin
               pos_ff <= '0;
               vc_ff  <= '0;
            end else if (vc_last) begin
               pos_ff <= pos_ff + 2'd1;
               vc_ff  <= '0;
            end else begin
               vc_ff <= vc_ff + VC_W'(1);
            end
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         port_ff   <= route.first + PORT_W'(idx);
         vc_out_ff <= route.all_vcs ? vc_ff : route.cur_vc;
         last_ff   <= is_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign out_port   = port_ff;
   assign out_vc     = vc_out_ff;
   assign out_last   = last_ff;

endmodule

/* sv/dimension_order_route_compute_core.sv */
// ---------------------------------------------------------------------------
// Dimension-order route compute core
// Takes a head flit's destination and current VC on the req_ stream and
// returns the set of output port and VC choices on the rsp_ stream.
//
// A request transaction carries the destination terminal, the packed
// destination coordinates and the current VC. Each request yields one or
// more response transactions in ascending port, then VC order; tlast marks
// the final choice of the route. A request yields (number of ports) x
// (VCs per port) responses: 1 to 64.
// Each request passes through the input register, the route register and
// the output register; the emitter delivers one response per cycle while
// rsp_tready is high. Requests that yield one response each are taken
// back to back; while a longer route is emitted, one further request
// waits in the input register and req_tready then stays low until the
// last response of that route is taken.
// When rsp_tready is low the output register holds its transaction and the
// stages behind it fill up before req_tready drops.
// The csr_ port writes one register per cycle; the user must write it only
// while no request is in flight (the block does not enforce this). Reset is
// synchronous, empties all stages and restores the default configuration.
// ---------------------------------------------------------------------------
module dimension_order_route_compute_core
   import dorc_pkg::*;
#(
   parameter int MAX_DIMS   = DIMS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [5:0] dest_terminal, [37:6] dest_coords, [41:38] current_vc, rest zero
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [12:0] out_port, [16:13] out_vc, rest zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tlast
);

   cfg_type           cfg;
   route_type         route;
   logic              route_valid;
   logic              route_release;
   logic [PORT_W-1:0] out_port;
   logic [VC_W-1:0]   out_vc;

   dorc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dorc_route #(
      .MAX_DIMS   (MAX_DIMS),
      .COORD_BITS (COORD_BITS)
   ) u_route (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .route_valid   (route_valid),
      .route         (route),
      .route_release (route_release)
   );

   dorc_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .route_valid   (route_valid),
      .route         (route),
      .route_release (route_release),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .out_port      (out_port),
      .out_vc        (out_vc),
      .out_last      (rsp_tlast)
   );

   assign rsp_tdata = {(RSP_TDATA_W-PORT_W-VC_W)'(0), out_vc, out_port};

endmodule
